// File: hw/rtl/grc_pkg.sv
// ----------------------------------------------------------------------------
// grc_pkg
// Shared constants and interface types of the grid ray caster.
// ----------------------------------------------------------------------------
package grc_pkg;

	// grid and world geometry
	localparam int MAP_SIDE   = 64;
	localparam int CELL_SIZE  = 64;
	localparam int MAP_BITS   = $clog2(MAP_SIDE);
	localparam int ADDR_BITS  = 2 * MAP_BITS;
	localparam int CFG_W      = 7;

	// one cell in world units with 8 fraction bits, a power of two
	localparam int C256       = CELL_SIZE * 256;
	localparam int C256_SHIFT = $clog2(C256);
	localparam int NUDGE      = C256 / 10;

	// angles and trig words
	localparam int FULL_TURN  = 5760;
	localparam int QUARTER    = 1440;
	localparam int ANG_W      = 13;
	localparam int ANG_BITS   = $clog2(QUARTER + 1);
	localparam int ONE_Q14    = 16384;
	localparam int TAB_W      = 15;
	localparam int TRIG_W     = TAB_W + 1;

	// datapath widths
	localparam int POS_W      = 40;
	localparam int DIST_W     = 21;
	localparam int DIST_MAX   = 2097151;
	localparam int MUL_OP_W   = DIST_W + 2;
	localparam int MUL_W      = 2 * MUL_OP_W;
	localparam int SQ_W       = 2 * DIST_W + 2;
	localparam int DIV_DW     = TAB_W + 1;
	localparam int DIV_NW     = C256_SHIFT + TAB_W + 1;

	// face codes
	localparam logic [1:0] SIDE_HN = 2'd0;
	localparam logic [1:0] SIDE_HP = 2'd1;
	localparam logic [1:0] SIDE_VN = 2'd2;
	localparam logic [1:0] SIDE_VP = 2'd3;

	// register indexes
	localparam logic REG_MAP_WIDTH  = 1'b0;
	localparam logic REG_MAP_HEIGHT = 1'b1;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic            start;
		logic [SQ_W-1:0] val;
	} sqrt_req_t;

	typedef struct packed {
		logic            done;
		logic [SQ_W-1:0] root;
	} sqrt_rsp_t;

	typedef struct packed {
		logic                 en;
		logic [ADDR_BITS-1:0] addr;
		logic                 data;
	} map_wr_t;

endpackage

// File: hw/rtl/grc_trig_rom.sv
// ----------------------------------------------------------------------------
// grc_trig_rom
// Quarter-wave sine table in unsigned Q1.14, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module grc_trig_rom import grc_pkg::*; (
	input  logic                clk,
	input  logic [ANG_BITS-1:0] addr,
	output logic [TAB_W-1:0]    data
);

	typedef logic [TAB_W-1:0] sin_tab_t [0:QUARTER];

	localparam logic [63:0] PI_Q30 = 64'd3373259426;

	// taylor series in q30, rounded to q14
	function automatic logic [TAB_W-1:0] quarter_sine(int unsigned r);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic signed [63:0] v;
		x    = (64'(r) * PI_Q30) / 64'(2 * QUARTER);
		x2   = (x * x) >> 30;
		term = x;
		sum  = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum  = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum  = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum  = sum + $signed(term);
		if (sum < 0) begin
			sum = 0;
		end
		v = (sum + 64'sd32768) >>> 16;
		if (v > 64'sd16384) begin
			v = 64'sd16384;
		end
		return v[TAB_W-1:0];
	endfunction

	function automatic sin_tab_t build_tab();
		sin_tab_t t;
		for (int r = 0; r <= QUARTER; r++) begin
			t[r] = quarter_sine(r);
		end
		return t;
	endfunction

	localparam sin_tab_t SIN_TAB = build_tab();

	// registered lookup
	always_ff @(posedge clk) begin
		data <= SIN_TAB[addr];
	end

endmodule

// File: hw/rtl/grc_div.sv
// ----------------------------------------------------------------------------
// grc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grc_div import grc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIV_NW-1:0] num_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_DW:0]   shifted;
	logic              fits;

	// trial subtract
	always_comb begin
		shifted = {rem_q, num_q[DIV_NW-1]};
		fits    = shifted >= {1'b0, den_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, quotient shifts in behind the dividend
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NW-2:0], fits};
			rem_q <= fits ? DIV_DW'(shifted - {1'b0, den_q}) : shifted[DIV_DW-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;

endmodule

// File: hw/rtl/grc_sqrt.sv
// ----------------------------------------------------------------------------
// grc_sqrt
// Truncating integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module grc_sqrt import grc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  sqrt_req_t req,
	output sqrt_rsp_t rsp
);

	logic            busy_q;
	logic            done_q;
	logic [SQ_W-1:0] v_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic [SQ_W-1:0] trial;
	logic            fits;

	always_comb begin
		trial = res_q + bit_q;
		fits  = v_q >= trial;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			v_q   <= req.val;
			res_q <= '0;
			bit_q <= SQ_W'(1) << (SQ_W - 2);
		end else if (busy_q) begin
			if (fits) begin
				v_q   <= v_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = res_q;

endmodule

// File: hw/rtl/grc_map.sv
// ----------------------------------------------------------------------------
// grc_map
// Wall-bit grid memory with a clearing pass after reset.
// ----------------------------------------------------------------------------
module grc_map import grc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  map_wr_t              wr,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic                 rd_data,
	output logic                 ready
);

	logic                 mem [0:(1 << ADDR_BITS)-1];
	logic                 clearing_q;
	logic [ADDR_BITS-1:0] clr_q;

	// clear sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + ADDR_BITS'(1);
			if (clr_q == '1) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// write and registered read
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_q] <= 1'b0;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

	assign ready = !clearing_q;

endmodule

// File: hw/rtl/grid_ray_caster_top.sv
// ----------------------------------------------------------------------------
// grid_ray_caster_top
// Grid ray caster: wall map, up to two grid walks per ray, nearest hit.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 4096-cell wall map to open floor;
// in_ready stays low until then while configuration writes are taken at once.
// A cast word runs a trig lookup and then, for each of the up to two walks,
// a setup in the bit-serial divider (two 30-bit divides), a probe and map
// read per cell stepped through the map memory port, and the distance in the
// bit-serial square root. One word is in work at a time; the result register
// lets the next word start while a result still waits.
// ----------------------------------------------------------------------------
module grid_ray_caster_top import grc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	// input words
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              op,
	input  logic [5:0]        cell_x,
	input  logic [5:0]        cell_y,
	input  logic              cell_is_wall,
	input  logic [13:0]       player_x,
	input  logic [13:0]       player_y,
	input  logic [ANG_W-1:0]  ray_angle,
	// result words
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DIST_W-1:0] hit_distance,
	output logic [1:0]        hit_side,
	output logic [5:0]        hit_cell_x,
	output logic [5:0]        hit_cell_y,
	output logic              hit_in_map
);

	typedef enum logic [18:0] {
		S_IDLE  = 19'h00001,
		S_SIN   = 19'h00002,
		S_COS   = 19'h00004,
		S_TRIG  = 19'h00008,
		S_WSET  = 19'h00010,
		S_MUL1  = 19'h00020,
		S_DIV1S = 19'h00040,
		S_DIV1W = 19'h00080,
		S_MUL2  = 19'h00100,
		S_DIV2S = 19'h00200,
		S_DIV2W = 19'h00400,
		S_PROBE = 19'h00800,
		S_LOOK  = 19'h01000,
		S_DIST  = 19'h02000,
		S_SQY   = 19'h04000,
		S_SQS   = 19'h08000,
		S_SQW   = 19'h10000,
		S_WEND  = 19'h20000,
		S_PICK  = 19'h40000
	} state_t;

	typedef struct packed {
		logic [ANG_BITS-1:0] idx;
		logic                neg;
	} trig_idx_t;

	// quadrant fold of an angle below a full turn
	function automatic trig_idx_t trig_index(logic [ANG_W-1:0] a);
		trig_idx_t        t;
		logic [ANG_W-1:0] r;
		priority if (a >= ANG_W'(3 * QUARTER)) begin
			r     = a - ANG_W'(3 * QUARTER);
			t.idx = ANG_BITS'(QUARTER - int'(r));
			t.neg = 1'b1;
		end else if (a >= ANG_W'(2 * QUARTER)) begin
			r     = a - ANG_W'(2 * QUARTER);
			t.idx = r[ANG_BITS-1:0];
			t.neg = 1'b1;
		end else if (a >= ANG_W'(QUARTER)) begin
			r     = a - ANG_W'(QUARTER);
			t.idx = ANG_BITS'(QUARTER - int'(r));
			t.neg = 1'b0;
		end else begin
			t.idx = a[ANG_BITS-1:0];
			t.neg = 1'b0;
		end
		return t;
	endfunction

	state_t state_q;

	logic [CFG_W-1:0]          mw_q;
	logic [CFG_W-1:0]          mh_q;
	logic                      wr_q;
	logic [13:0]               px_q;
	logic [13:0]               py_q;
	trig_idx_t                 sti_q;
	trig_idx_t                 cti_q;
	logic signed [TRIG_W-1:0]  s_q;
	logic signed [TRIG_W-1:0]  c_q;
	logic                      hv_q;
	logic                      vv_q;
	logic                      horiz_q;
	logic signed [TRIG_W-1:0]  a0_q;
	logic signed [TRIG_W-1:0]  sa_q;
	logic signed [POS_W-1:0]   b0_q;
	logic signed [MUL_W-1:0]   prod_q;
	logic signed [POS_W-1:0]   ox_q;
	logic signed [POS_W-1:0]   oy_q;
	logic signed [POS_W-1:0]   sx_q;
	logic signed [POS_W-1:0]   sy_q;
	logic [MAP_BITS-1:0]       cx_q;
	logic [MAP_BITS-1:0]       cy_q;
	logic                      in_q;
	logic [SQ_W-1:0]           acc_q;
	logic [DIST_W-1:0]         wdist_q;
	logic [DIST_W-1:0]         h_dist_q;
	logic [MAP_BITS-1:0]       h_cx_q;
	logic [MAP_BITS-1:0]       h_cy_q;
	logic                      h_in_q;
	logic [DIST_W-1:0]         v_dist_q;
	logic [MAP_BITS-1:0]       v_cx_q;
	logic [MAP_BITS-1:0]       v_cy_q;
	logic                      v_in_q;
	logic                      out_valid_q;
	logic [DIST_W-1:0]         dist_q;
	logic [1:0]                side_q;
	logic [5:0]                ocx_q;
	logic [5:0]                ocy_q;
	logic                      oin_q;

	logic                      in_acc;
	logic [ANG_W-1:0]          a_red;
	logic [ANG_W-1:0]          a_cos;
	logic [ANG_BITS-1:0]       rom_addr;
	logic [TAB_W-1:0]          rom_data;
	logic signed [TRIG_W-1:0]  rom_val;
	logic signed [TRIG_W-1:0]  c_new;
	logic signed [TRIG_W-1:0]  t_sel;
	logic signed [TRIG_W-1:0]  u_sel;
	logic signed [TRIG_W-1:0]  u_abs;
	logic signed [TRIG_W-1:0]  a0_new;
	logic signed [TRIG_W-1:0]  sa_new;
	logic signed [MUL_OP_W-1:0] mul_a;
	logic signed [MUL_OP_W-1:0] mul_b;
	logic signed [MUL_W-1:0]   prod_abs;
	logic                      div_neg;
	logic signed [POS_W-1:0]   div_q;
	logic signed [POS_W-1:0]   div_res;
	logic signed [POS_W-1:0]   nud;
	logic signed [POS_W-1:0]   pxw;
	logic signed [POS_W-1:0]   pyw;
	logic signed [POS_W-1:0]   posx;
	logic signed [POS_W-1:0]   posy;
	logic [CFG_W-1:0]          w_eff;
	logic [CFG_W-1:0]          h_eff;
	logic                      probe_in;
	logic [MAP_BITS-1:0]       tx;
	logic [MAP_BITS-1:0]       ty;
	logic [POS_W-1:0]          ax;
	logic [POS_W-1:0]          ay;
	logic                      dist_sat;
	logic [1:0]                hside;
	logic [1:0]                vside;
	logic [1:0]                pick_side;
	logic                      pick_v;
	logic                      out_load;

	div_req_t  div_req;
	div_rsp_t  div_rsp;
	sqrt_req_t sq_req;
	sqrt_rsp_t sq_rsp;
	map_wr_t   map_wr;
	logic      map_rd;
	logic      map_ready;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE) && map_ready;
	assign in_acc    = in_valid && in_ready;

	// angle reduction at accept
	always_comb begin
		a_red = (ray_angle >= ANG_W'(FULL_TURN)) ? ray_angle - ANG_W'(FULL_TURN) : ray_angle;
		a_cos = a_red + ANG_W'(QUARTER);
		if (a_cos >= ANG_W'(FULL_TURN)) begin
			a_cos = a_cos - ANG_W'(FULL_TURN);
		end
	end

	// trig table
	assign rom_addr = (state_q == S_COS) ? cti_q.idx : sti_q.idx;

	grc_trig_rom u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	always_comb begin
		rom_val = $signed({1'b0, rom_data});
		c_new   = cti_q.neg ? -rom_val : rom_val;
	end

	// walk setup operands
	always_comb begin
		int frac;
		if (horiz_q) begin
			frac   = CELL_SIZE * int'(py_q[7:0]);
			a0_new = TRIG_W'((s_q < 0 ? C256 : 0) - frac);
			sa_new = TRIG_W'(s_q >= 0 ? -C256 : C256);
			t_sel  = c_q;
			u_sel  = s_q;
		end else begin
			frac   = CELL_SIZE * int'(px_q[7:0]);
			a0_new = TRIG_W'((c_q >= 0 ? C256 : 0) - frac);
			sa_new = TRIG_W'(c_q >= 0 ? C256 : -C256);
			t_sel  = s_q;
			u_sel  = c_q;
		end
		u_abs = u_sel[TRIG_W-1] ? -u_sel : u_sel;
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_MUL1: begin
				mul_a = -MUL_OP_W'(a0_q);
				mul_b = MUL_OP_W'(t_sel);
			end
			S_MUL2: begin
				mul_a = -MUL_OP_W'(sa_q);
				mul_b = MUL_OP_W'(t_sel);
			end
			S_DIST: begin
				mul_a = $signed({2'b00, ax[DIST_W-1:0]});
				mul_b = $signed({2'b00, ax[DIST_W-1:0]});
			end
			S_SQY: begin
				mul_a = $signed({2'b00, ay[DIST_W-1:0]});
				mul_b = $signed({2'b00, ay[DIST_W-1:0]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// rounded divide, halves away from zero
	always_comb begin
		prod_abs      = prod_q[MUL_W-1] ? -prod_q : prod_q;
		div_neg       = prod_q[MUL_W-1] != u_sel[TRIG_W-1];
		div_req.start = (state_q == S_DIV1S) || (state_q == S_DIV2S);
		div_req.num   = {prod_abs[DIV_NW-2:0], 1'b0} + DIV_NW'(u_abs[TAB_W-1:0]);
		div_req.den   = {u_abs[TAB_W-1:0], 1'b0};
		div_q         = $signed(POS_W'(div_rsp.quot));
		div_res       = div_neg ? -div_q : div_q;
	end

	grc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// cell probe of the current crossing
	always_comb begin
		nud   = sa_q[TRIG_W-1] ? -POS_W'(NUDGE) : POS_W'(NUDGE);
		pxw   = $signed(POS_W'(px_q) * POS_W'(CELL_SIZE));
		pyw   = $signed(POS_W'(py_q) * POS_W'(CELL_SIZE));
		posx  = ox_q + pxw + (horiz_q ? '0 : nud);
		posy  = oy_q + pyw + (horiz_q ? nud : '0);
		w_eff = (mw_q > CFG_W'(MAP_SIDE)) ? CFG_W'(MAP_SIDE) : mw_q;
		h_eff = (mh_q > CFG_W'(MAP_SIDE)) ? CFG_W'(MAP_SIDE) : mh_q;
		probe_in = !posx[POS_W-1] && !posy[POS_W-1]
			&& (posx[POS_W-1:C256_SHIFT] < (POS_W - C256_SHIFT)'(w_eff))
			&& (posy[POS_W-1:C256_SHIFT] < (POS_W - C256_SHIFT)'(h_eff));
		tx = posx[C256_SHIFT +: MAP_BITS];
		ty = posy[C256_SHIFT +: MAP_BITS];
	end

	assign map_wr.en   = in_acc && !op;
	assign map_wr.addr = {cell_y, cell_x};
	assign map_wr.data = cell_is_wall;

	grc_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (map_wr),
		.rd_addr ({ty, tx}),
		.rd_data (map_rd),
		.ready   (map_ready)
	);

	// distance operands
	always_comb begin
		ax       = ox_q[POS_W-1] ? POS_W'(-ox_q) : POS_W'(ox_q);
		ay       = oy_q[POS_W-1] ? POS_W'(-oy_q) : POS_W'(oy_q);
		dist_sat = (ax > POS_W'(DIST_MAX)) || (ay > POS_W'(DIST_MAX));
		sq_req.start = (state_q == S_SQS);
		sq_req.val   = acc_q + prod_q[SQ_W-1:0];
	end

	grc_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	// nearer hit select
	always_comb begin
		hside = s_q[TRIG_W-1] ? SIDE_HN : SIDE_HP;
		vside = c_q[TRIG_W-1] ? SIDE_VN : SIDE_VP;
		priority if (hv_q && vv_q) begin
			pick_side = (h_dist_q <= v_dist_q) ? hside : vside;
			pick_v    = v_dist_q <= h_dist_q;
		end else if (hv_q) begin
			pick_side = hside;
			pick_v    = 1'b0;
		end else begin
			pick_side = vside;
			pick_v    = 1'b1;
		end
		out_load = (state_q == S_PICK) && (!out_valid_q || out_ready);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mw_q <= CFG_W'(64);
			mh_q <= CFG_W'(64);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAP_WIDTH:  mw_q <= cfg_data;
				REG_MAP_HEIGHT: mh_q <= cfg_data;
				default:        mw_q <= mw_q;
			endcase
		end
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:  if (in_acc) state_q <= op ? S_SIN : S_PICK;
				S_SIN:   state_q <= S_COS;
				S_COS:   state_q <= S_TRIG;
				S_TRIG:  state_q <= S_WSET;
				S_WSET:  state_q <= S_MUL1;
				S_MUL1:  state_q <= S_DIV1S;
				S_DIV1S: state_q <= S_DIV1W;
				S_DIV1W: if (div_rsp.done) state_q <= S_MUL2;
				S_MUL2:  state_q <= S_DIV2S;
				S_DIV2S: state_q <= S_DIV2W;
				S_DIV2W: if (div_rsp.done) state_q <= S_PROBE;
				S_PROBE: state_q <= probe_in ? S_LOOK : S_DIST;
				S_LOOK:  state_q <= map_rd ? S_DIST : S_PROBE;
				S_DIST:  state_q <= dist_sat ? S_WEND : S_SQY;
				S_SQY:   state_q <= S_SQS;
				S_SQS:   state_q <= S_SQW;
				S_SQW:   if (sq_rsp.done) state_q <= S_WEND;
				S_WEND:  state_q <= (horiz_q && vv_q) ? S_WSET : S_PICK;
				S_PICK:  if (out_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			wr_q  <= !op;
			px_q  <= player_x;
			py_q  <= player_y;
			sti_q <= trig_index(a_red);
			cti_q <= trig_index(a_cos);
		end
		if (state_q == S_COS) begin
			s_q <= sti_q.neg ? -rom_val : rom_val;
		end
		if (state_q == S_TRIG) begin
			c_q     <= c_new;
			hv_q    <= (c_new != TRIG_W'(ONE_Q14)) && (c_new != -TRIG_W'(ONE_Q14));
			vv_q    <= (s_q != TRIG_W'(ONE_Q14)) && (s_q != -TRIG_W'(ONE_Q14));
			horiz_q <= (c_new != TRIG_W'(ONE_Q14)) && (c_new != -TRIG_W'(ONE_Q14));
		end
		if (state_q == S_WSET) begin
			a0_q <= a0_new;
			sa_q <= sa_new;
		end
		// shared multiplier output
		if ((state_q == S_MUL1) || (state_q == S_MUL2) ||
		    ((state_q == S_DIST) && !dist_sat) || (state_q == S_SQY)) begin
			prod_q <= mul_a * mul_b;
		end
		if ((state_q == S_DIV1W) && div_rsp.done) begin
			b0_q <= div_res;
		end
		// walk start point and step
		if ((state_q == S_DIV2W) && div_rsp.done) begin
			if (horiz_q) begin
				oy_q <= POS_W'(a0_q);
				sy_q <= POS_W'(sa_q);
				ox_q <= b0_q;
				sx_q <= div_res;
			end else begin
				ox_q <= POS_W'(a0_q);
				sx_q <= POS_W'(sa_q);
				oy_q <= b0_q;
				sy_q <= div_res;
			end
		end
		if (state_q == S_PROBE) begin
			in_q <= probe_in;
			cx_q <= probe_in ? tx : '0;
			cy_q <= probe_in ? ty : '0;
		end
		if ((state_q == S_LOOK) && !map_rd) begin
			ox_q <= ox_q + sx_q;
			oy_q <= oy_q + sy_q;
		end
		if ((state_q == S_DIST) && dist_sat) begin
			wdist_q <= DIST_W'(DIST_MAX);
		end
		if (state_q == S_SQY) begin
			acc_q <= prod_q[SQ_W-1:0];
		end
		if ((state_q == S_SQW) && sq_rsp.done) begin
			wdist_q <= (sq_rsp.root > SQ_W'(DIST_MAX)) ? DIST_W'(DIST_MAX)
				: sq_rsp.root[DIST_W-1:0];
		end
		// walk result store
		if (state_q == S_WEND) begin
			if (horiz_q) begin
				h_dist_q <= wdist_q;
				h_cx_q   <= cx_q;
				h_cy_q   <= cy_q;
				h_in_q   <= in_q;
				horiz_q  <= 1'b0;
			end else begin
				v_dist_q <= wdist_q;
				v_cx_q   <= cx_q;
				v_cy_q   <= cy_q;
				v_in_q   <= in_q;
			end
		end
		// result register
		if (out_load) begin
			if (wr_q) begin
				dist_q <= '0;
				side_q <= SIDE_HN;
				ocx_q  <= '0;
				ocy_q  <= '0;
				oin_q  <= 1'b0;
			end else begin
				dist_q <= pick_v ? v_dist_q : h_dist_q;
				side_q <= pick_side;
				ocx_q  <= pick_v ? v_cx_q : h_cx_q;
				ocy_q  <= pick_v ? v_cy_q : h_cy_q;
				oin_q  <= pick_v ? v_in_q : h_in_q;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign hit_distance = dist_q;
	assign hit_side     = side_q;
	assign hit_cell_x   = ocx_q;
	assign hit_cell_y   = ocy_q;
	assign hit_in_map   = oin_q;

endmodule

// File: hw/rtl/grc_checker.sv
// ----------------------------------------------------------------------------
// grc_checker
// Port-level checks of the grid ray caster, bound to the top level.
// ----------------------------------------------------------------------------
module grc_checker import grc_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [DIST_W-1:0] hit_distance,
	input logic [1:0]        hit_side,
	input logic [5:0]        hit_cell_x,
	input logic [5:0]        hit_cell_y,
	input logic              hit_in_map
);

	// one word in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready stayed high after an accepted word");

	// a new result only appears while the input side is closed
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a word in work");

	// a miss reports cell zero
	a_miss_cell_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit_in_map) |-> (hit_cell_x == 6'd0 && hit_cell_y == 6'd0))
		else $error("off-map hit with nonzero cell");

	// stalled result holds its valid, distance and side
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(hit_distance)
			&& $stable(hit_side)))
		else $error("stalled result changed");

endmodule

bind grid_ray_caster_top grc_checker u_grc_checker (.*);
